// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes for the stable priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_PEEK   = 2'd2;

    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_BADPOS = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] priority_req;
        logic [15:0] payload_tag;
        logic [15:0] packet_size;
        logic [3:0]  position;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] tag_out;
        logic [15:0] size_out;
        logic [31:0] priority_out;
        logic [4:0]  occupancy;
    } t_res;

    typedef struct packed {
        logic [31:0] pri;
        logic [15:0] tag;
        logic [15:0] size;
    } t_entry;

    // broadcast from the control to every cell
    typedef struct packed {
        logic   ins_en;
        logic   rem_en;
        t_entry new_entry;
    } t_cell_ctrl;

endpackage

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry, shifts left or right
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                i_clk,
    input  logic                i_valid,
    input  logic                i_past_pos,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_entry     i_left_entry,
    input  logic                i_left_gt,
    input  spq_pkg::t_entry     i_right_entry,
    output spq_pkg::t_entry     o_entry,
    output logic                o_gt
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // valid entry with a larger key than the one being inserted
    assign o_gt    = i_valid && (r_entry.pri > i_ctrl.new_entry.pri);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins_en) begin
            // stays only when it holds a key at or below the new one
            if (!(i_valid && (r_entry.pri <= i_ctrl.new_entry.pri))) begin
                n_entry = i_left_gt ? i_left_entry : i_ctrl.new_entry;
            end
        end else if (i_ctrl.rem_en && i_past_pos) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- rtl/stable_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue
// sorted queue of packet entries held in a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// One request (insert, remove at rank, peek at rank) is taken per clock
// while o_busy is low, which it always is: every cell compares its key with
// the new one in parallel and the whole chain shifts in the accept cycle.
// The answer appears on o_res with o_done high for exactly one cycle, the
// cycle after the request; the receiver cannot hold it off, so it must
// capture it then. Equal keys leave in arrival order. Insert into a full
// queue answers the full status, a rank at or past the occupancy answers
// the bad-position status, and neither changes the queue.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  spq_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_done,
    output spq_pkg::t_res o_res
);
    import spq_pkg::*;

    // count width holds the depth itself
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    // common width for comparing ranks with cell indices
    localparam int RW = (CW > 4) ? CW : 4;

    logic          r_done;
    t_res          r_res;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    t_res          n_res;

    logic          w_accept;
    logic          w_full;
    logic          w_pos_ok;
    logic [RW-1:0] w_pos;
    logic          w_is_ins;
    logic          w_is_rd;
    t_cell_ctrl    w_ctrl;
    t_entry        w_sel;

    t_entry        w_entry [QUEUE_DEPTH];
    logic          w_gt    [QUEUE_DEPTH];
    t_entry        w_pick  [QUEUE_DEPTH];

    // the chain never needs more than the accept cycle
    assign o_busy   = 1'b0;
    assign w_accept = i_start;

    assign w_pos    = RW'(i_req.position);
    assign w_full   = (r_count == CW'(QUEUE_DEPTH));
    assign w_pos_ok = (w_pos < RW'(r_count));
    assign w_is_ins = (i_req.kind == KIND_INSERT);
    assign w_is_rd  = (i_req.kind == KIND_REMOVE) || (i_req.kind == KIND_PEEK);

    // broadcast to the cells: only legal operations touch the chain
    always_comb begin
        w_ctrl.ins_en        = w_accept && w_is_ins && !w_full;
        w_ctrl.rem_en        = w_accept && (i_req.kind == KIND_REMOVE) && w_pos_ok;
        w_ctrl.new_entry.pri  = i_req.priority_req;
        w_ctrl.new_entry.tag  = i_req.payload_tag;
        w_ctrl.new_entry.size = i_req.packet_size;
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            t_entry w_left;
            logic   w_left_gt;
            t_entry w_right;

            if (g == 0) begin : g_head
                assign w_left    = w_ctrl.new_entry;
                assign w_left_gt = 1'b0;
            end else begin : g_body
                assign w_left    = w_entry[g-1];
                assign w_left_gt = w_gt[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign w_right = w_entry[g];
            end else begin : g_inner
                assign w_right = w_entry[g+1];
            end

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_valid       (CW'(g) < r_count),
                .i_past_pos    (RW'(g) >= w_pos),
                .i_ctrl        (w_ctrl),
                .i_left_entry  (w_left),
                .i_left_gt     (w_left_gt),
                .i_right_entry (w_right),
                .o_entry       (w_entry[g]),
                .o_gt          (w_gt[g])
            );

            // one-hot pick of the ranked entry, or-ed down the chain
            if (g == 0) begin : g_pick0
                assign w_pick[g] = (RW'(g) == w_pos) ? w_entry[g] : '0;
            end else begin : g_pickn
                assign w_pick[g] = w_pick[g-1] |
                                   ((RW'(g) == w_pos) ? w_entry[g] : '0);
            end
        end
    endgenerate

    assign w_sel = w_pick[QUEUE_DEPTH-1];

    // next occupancy and the answer for this request
    always_comb begin
        n_count = r_count;
        n_res   = '0;
        if (w_ctrl.ins_en) begin
            n_count = r_count + CW'(1);
        end else if (w_ctrl.rem_en) begin
            n_count = r_count - CW'(1);
        end

        if (w_is_ins) begin
            n_res.status = w_full ? STATUS_FULL : STATUS_DONE;
        end else if (w_is_rd) begin
            if (w_pos_ok) begin
                n_res.status       = STATUS_DONE;
                n_res.tag_out      = w_sel.tag;
                n_res.size_out     = w_sel.size;
                n_res.priority_out = w_sel.pri;
            end else begin
                n_res.status = STATUS_BADPOS;
            end
        end
        n_res.occupancy = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            r_done <= w_accept;
        end
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- bench/stable_priority_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_tb
// self-checking bench for the sorted packet queue
// ----------------------------------------------------------------------------
// Requests come from a queue that is filled at time zero: a short directed
// run first (empty queue, ties, extreme keys and fields, a full queue, bad
// ranks, the unused kind), then three random phases of mostly well-formed traffic
// (with now and then the unused kind or a bad rank) that swings the queue
// between empty and full. A shadow copy of the queue predicts every answer;
// the monitor compares each answer field by field with the oldest
// prediction. The sender idles at random and drains the queue of pending answers at the start of each phase.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;

    import spq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    // kind code the block does not use
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // cycles with neither a request nor an answer before giving up
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 150;
    localparam int MAX_REPORTS = 10;

    // one request waiting to be sent, with its sending rules
    typedef struct {
        t_req        req;
        bit          drain;     // hold off until every answer has come
        int unsigned idle_pct;  // chance in a hundred of an idle cycle
    } t_queued_req;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_req i_req   = '0;
    logic o_busy;
    logic o_done;
    t_res o_res;

    stable_priority_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    // shadow copy of the queue contents
    t_entry      model_store [DEPTH];
    int unsigned model_count = 0;

    t_queued_req requests_todo [$];
    t_res        answers_due [$];
    int unsigned n_issued   = 0;
    int unsigned n_answered = 0;
    int unsigned n_errors   = 0;
    int unsigned n_stall    = 0;

    // request generation state
    int unsigned gen_count    = 0;
    int unsigned gen_idle_pct = 11;
    bit          gen_drain    = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predicted answer for one request, updating the shadow queue
    // ------------------------------------------------------------------------
    function automatic t_res queue_model_step(input t_req r);
        t_res        res;
        int unsigned slot;
        int unsigned i;
        res = '0;
        res.status = STATUS_DONE;
        case (r.kind)
            KIND_INSERT: begin
                if (model_count >= DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    // stable: go past every entry with an equal or smaller key
                    slot = 0;
                    while (slot < model_count && model_store[slot].pri <= r.priority_req)
                        slot++;
                    for (i = model_count; i > slot; i--)
                        model_store[i] = model_store[i - 1];
                    model_store[slot].pri  = r.priority_req;
                    model_store[slot].tag  = r.payload_tag;
                    model_store[slot].size = r.packet_size;
                    model_count++;
                end
            end
            KIND_REMOVE, KIND_PEEK: begin
                if (r.position >= model_count) begin
                    res.status = STATUS_BADPOS;
                end else begin
                    res.tag_out      = model_store[r.position].tag;
                    res.size_out     = model_store[r.position].size;
                    res.priority_out = model_store[r.position].pri;
                    if (r.kind == KIND_REMOVE) begin
                        for (i = r.position; i + 1 < model_count; i++)
                            model_store[i] = model_store[i + 1];
                        model_count--;
                    end
                end
            end
            default: ;  // unused kind leaves the queue alone
        endcase
        res.occupancy = 5'(model_count);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // request generation
    // ------------------------------------------------------------------------
    // queues one request and tracks the occupancy it will leave behind
    task automatic add_req(input logic [1:0] k, input logic [31:0] pri,
                           input logic [15:0] tag, input logic [15:0] size,
                           input logic [3:0] pos);
        t_queued_req q;
        q.req.kind         = k;
        q.req.priority_req = pri;
        q.req.payload_tag  = tag;
        q.req.packet_size  = size;
        q.req.position     = pos;
        q.drain            = gen_drain;
        q.idle_pct         = gen_idle_pct;
        gen_drain          = 1'b0;
        requests_todo.push_back(q);
        if (k == KIND_INSERT && gen_count < DEPTH)
            gen_count++;
        else if (k == KIND_REMOVE && pos < gen_count)
            gen_count--;
    endtask

    // keys bunched on a few values so that ties are common
    function automatic logic [31:0] pick_priority();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return 32'($urandom_range(7));
        else if (r < 45)
            return 32'h0000_0000;
        else if (r < 50)
            return 32'hFFFF_FFFF;
        else
            return $urandom;
    endfunction

    // mostly valid ranks, now and then any rank at all
    function automatic logic [3:0] pick_position();
        if (gen_count > 0 && $urandom_range(99) < 85)
            return 4'($urandom_range(gen_count - 1));
        else
            return 4'($urandom_range(15));
    endfunction

    task automatic add_random_phase(input int unsigned idle_pct);
        int unsigned n;
        int unsigned r;
        bit          filling;
        gen_idle_pct = idle_pct;
        gen_drain    = 1'b1;
        filling      = 1'b1;
        for (n = 0; n < PHASE_ITEMS; n++) begin
            // swing between filling up and draining down
            if (gen_count == 0)
                filling = 1'b1;
            else if (gen_count == DEPTH && $urandom_range(3) != 0)
                filling = 1'b0;
            r = $urandom_range(99);
            if (r < 3)
                add_req(KIND_UNUSED, $urandom, 16'($urandom), 16'($urandom),
                        4'($urandom));
            else if (r < (filling ? 70 : 30))
                add_req(KIND_INSERT, pick_priority(), 16'($urandom), 16'($urandom),
                        4'($urandom));
            else if ($urandom_range(99) < 60)
                add_req(KIND_REMOVE, $urandom, 16'($urandom), 16'($urandom),
                        pick_position());
            else
                add_req(KIND_PEEK, $urandom, 16'($urandom), 16'($urandom),
                        pick_position());
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned i;

        // empty queue: bad ranks at both ends and the unused kind
        add_req(KIND_PEEK,    32'd0, 16'h0000, 16'h0000, 4'd0);
        add_req(KIND_REMOVE,  32'd0, 16'h0000, 16'h0000, 4'd15);
        add_req(KIND_UNUSED,  32'd0, 16'h0000, 16'h0000, 4'd0);
        // extreme keys and fields, plus a run of equal keys
        add_req(KIND_INSERT,  32'd5,         16'h0001, 16'h0000, 4'd0);
        add_req(KIND_INSERT,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 4'd0);
        add_req(KIND_INSERT,  32'd0,         16'h0000, 16'hFFFF, 4'd0);
        add_req(KIND_INSERT,  32'd5,         16'h0002, 16'h1234, 4'd0);
        add_req(KIND_INSERT,  32'd5,         16'h0003, 16'h5678, 4'd0);
        add_req(KIND_PEEK,    32'd0,         16'h0000, 16'h0000, 4'd1);
        // fill to the brim
        for (i = 0; i < 11; i++)
            add_req(KIND_INSERT, 32'(i * 3), 16'($urandom), 16'($urandom), 4'd0);
        // full queue refuses, then work at the tail, the middle and the head
        add_req(KIND_INSERT,  32'd1,  16'hAAAA, 16'h5555, 4'd0);
        add_req(KIND_PEEK,    32'd0,  16'h0000, 16'h0000, 4'd15);
        add_req(KIND_REMOVE,  32'd0,  16'h0000, 16'h0000, 4'd15);
        add_req(KIND_PEEK,    32'd0,  16'h0000, 16'h0000, 4'd15);
        add_req(KIND_REMOVE,  32'd0,  16'h0000, 16'h0000, 4'd2);
        add_req(KIND_REMOVE,  32'd0,  16'h0000, 16'h0000, 4'd0);
        add_req(KIND_UNUSED,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 4'd15);

        // random phases: light sender idling, heavy idling, none
        add_random_phase(11);
        add_random_phase(78);
        add_random_phase(0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every request sent and every answer back
        while (!(requests_todo.size() == 0 && i_start == 1'b0 &&
                 n_answered == n_issued))
            @(posedge i_clk);
        // the answer is registered, so wait on to catch any stray answer
        repeat (8) @(posedge i_clk);

        if (answers_due.size() != 0) begin
            if (n_errors < MAX_REPORTS)
                $display("missing answers: %0d still due", answers_due.size());
            n_errors += answers_due.size();
        end
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // driver: holds a request until accepted, then picks the next one
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_queued_req nxt;
        logic        accepted;
        logic        start_next;
        if (i_rst_n) begin
            accepted = i_start && !o_busy;
            if (accepted) begin
                answers_due.push_back(queue_model_step(i_req));
                n_issued++;
            end
            if (!i_start || accepted) begin
                start_next = 1'b0;
                if (requests_todo.size() != 0) begin
                    // a drain point waits for every answer to come back
                    if (requests_todo[0].drain && (accepted || n_answered != n_issued))
                        start_next = 1'b0;
                    else if ($urandom_range(99) < requests_todo[0].idle_pct)
                        start_next = 1'b0;
                    else begin
                        nxt = requests_todo.pop_front();
                        i_req <= nxt.req;
                        start_next = 1'b1;
                    end
                end
                i_start <= start_next;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: each answer against the oldest prediction
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("mismatch on %s at %0t: expected %h, got %h",
                         name, $realtime, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_done === 1'b1) begin
            n_answered <= n_answered + 1;
            if (answers_due.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected answer at %0t: %h", $realtime, o_res);
            end else begin
                want = answers_due.pop_front();
                check_field("status",       32'(want.status),    32'(o_res.status));
                check_field("tag_out",      32'(want.tag_out),   32'(o_res.tag_out));
                check_field("size_out",     32'(want.size_out),  32'(o_res.size_out));
                check_field("priority_out", want.priority_out,   o_res.priority_out);
                check_field("occupancy",    32'(want.occupancy), 32'(o_res.occupancy));
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long with neither a request taken nor an answer seen
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_done === 1'b1)
                n_stall <= 0;
            else
                n_stall <= n_stall + 1;
            if (n_stall >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
